// ===== rtl/gpjd_pkg.sv =====
// ---------------------------------------------------------------------------
// gpjd_pkg
// Shared constants, trajectory tables and types for the gait phase joint drive.
// ---------------------------------------------------------------------------
package gpjd_pkg;

  localparam int ROM_SIZE     = 100;
  localparam int TABLE_LENGTH = 100;
  localparam int ANG_W        = 8;
  localparam int PHASE_W      = 7;
  localparam int CODE_W       = 4;
  localparam int CLAMP_W      = 6;
  localparam int SEARCH_SPAN  = 4;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CLAMP_W-1:0] HIP_CLAMP  = 6'd49;
  localparam int                 RISE_END   = 59;
  localparam int                 FALL_START = 58;
  localparam logic [7:0]         PHASE_MOD  = 8'd95;
  localparam logic [PHASE_W-1:0] SEED_HIGH  = 7'd75;
  localparam logic [PHASE_W-1:0] SEED_LOW   = 7'd35;
  localparam logic [ANG_W-1:0]   SEED_SPLIT = 8'd21;

  // floor(x / 9) = (x * 57) >> 9 and floor(x / 12) = (x * 171) >> 11 for x < 256
  localparam logic [5:0] KNEE_RECIP  = 6'd57;
  localparam int         KNEE_SHIFT  = 9;
  localparam logic [7:0] ANKLE_RECIP = 8'd171;
  localparam int         ANKLE_SHIFT = 11;

  localparam logic [6:0] RST_LATE_THR  = 7'd56;
  localparam logic [7:0] RST_LOW_HIP   = 8'd2;
  localparam logic [4:0] RST_PHASE_ADV = 5'd5;
  localparam logic [7:0] RST_ANKLE_OFS = 8'd133;

  localparam logic [CODE_W-1:0] CODE_NONE        = 4'b0000;
  localparam logic [CODE_W-1:0] CODE_KNEE_RAISE  = 4'b1000;
  localparam logic [CODE_W-1:0] CODE_KNEE_LOWER  = 4'b0100;
  localparam logic [CODE_W-1:0] CODE_ANKLE_RAISE = 4'b0010;
  localparam logic [CODE_W-1:0] CODE_ANKLE_LOWER = 4'b0001;

  typedef enum logic [0:0] {
    ACT_INIT = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LATE_THR  = 2'd0,
    CFG_LOW_HIP   = 2'd1,
    CFG_PHASE_ADV = 2'd2,
    CFG_ANKLE_OFS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEL1,
    ST_SEL2,
    ST_CODE,
    ST_DRIVE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] rise;
    logic [PHASE_W-1:0] fall;
  } scan_stat_t;

  localparam logic [5:0] HIP_ROM [ROM_SIZE] = '{
    6'd49, 6'd49, 6'd49, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48,
    6'd48, 6'd48, 6'd47, 6'd47, 6'd46, 6'd46, 6'd45, 6'd44, 6'd43, 6'd42,
    6'd41, 6'd40, 6'd39, 6'd38, 6'd37, 6'd35, 6'd34, 6'd33, 6'd31, 6'd30,
    6'd28, 6'd27, 6'd25, 6'd23, 6'd22, 6'd20, 6'd19, 6'd17, 6'd16, 6'd15,
    6'd14, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd7,  6'd6,  6'd5,  6'd5,
    6'd4,  6'd4,  6'd3,  6'd3,  6'd2,  6'd2,  6'd2,  6'd1,  6'd1,  6'd1,
    6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd11, 6'd13, 6'd14, 6'd16, 6'd18, 6'd21, 6'd23, 6'd25, 6'd27, 6'd30,
    6'd32, 6'd34, 6'd36, 6'd38, 6'd39, 6'd41, 6'd42, 6'd43, 6'd45, 6'd46,
    6'd47, 6'd47, 6'd48, 6'd48, 6'd48, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49
  };

  // knee target divided by 9, truncated toward zero
  localparam logic [2:0] KNEE_Q_ROM [ROM_SIZE] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
    3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1
  };

  localparam logic [5:0] ANKLE_ROM [ROM_SIZE] = '{
    6'd45, 6'd46, 6'd46, 6'd46, 6'd46, 6'd45, 6'd45, 6'd44, 6'd42, 6'd40,
    6'd39, 6'd38, 6'd37, 6'd36, 6'd36, 6'd35, 6'd35, 6'd35, 6'd35, 6'd36,
    6'd36, 6'd37, 6'd38, 6'd39, 6'd39, 6'd40, 6'd40, 6'd41, 6'd41, 6'd42,
    6'd42, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44,
    6'd44, 6'd44, 6'd45, 6'd45, 6'd46, 6'd46, 6'd46, 6'd47, 6'd47, 6'd47,
    6'd47, 6'd47, 6'd47, 6'd46, 6'd46, 6'd45, 6'd44, 6'd42, 6'd40, 6'd37,
    6'd35, 6'd32, 6'd28, 6'd26, 6'd23, 6'd21, 6'd19, 6'd18, 6'd17, 6'd16,
    6'd16, 6'd16, 6'd17, 6'd18, 6'd20, 6'd21, 6'd23, 6'd25, 6'd26, 6'd28,
    6'd30, 6'd31, 6'd32, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
    6'd40, 6'd41, 6'd42, 6'd42, 6'd43, 6'd43, 6'd44, 6'd44, 6'd45, 6'd45
  };

endpackage

// ===== rtl/gpjd_scan.sv =====
// ---------------------------------------------------------------------------
// gpjd_scan
// Hip trajectory search: walks the ROM one entry per cycle and matches the rising
// search offsets (below RISE_END) and the falling ones (from FALL_START) against that entry.
// ---------------------------------------------------------------------------
module gpjd_scan #(
  parameter int TABLE_LENGTH = gpjd_pkg::TABLE_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gpjd_pkg::CLAMP_W-1:0] hip_clamped,
  output gpjd_pkg::scan_stat_t        stat
);
  import gpjd_pkg::*;

  localparam int ScanEnd = (TABLE_LENGTH < ROM_SIZE) ? TABLE_LENGTH : ROM_SIZE;
  localparam int IdxW    = $clog2(ROM_SIZE);

  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SEARCH_SPAN-1:0] rise_hit_r, rise_hit_nxt;
  logic [SEARCH_SPAN-1:0] fall_hit_r, fall_hit_nxt;
  logic [PHASE_W-1:0] rise_idx_r [SEARCH_SPAN];
  logic [PHASE_W-1:0] rise_idx_nxt [SEARCH_SPAN];
  logic [PHASE_W-1:0] fall_idx_r [SEARCH_SPAN];
  logic [PHASE_W-1:0] fall_idx_nxt [SEARCH_SPAN];
  logic [7:0]         entry;
  logic               in_rise;
  logic               in_fall;

  always_comb begin
    entry   = {2'b00, HIP_ROM[idx_r]};
    in_rise = (int'(idx_r) < RISE_END);
    in_fall = (int'(idx_r) >= FALL_START);
    idx_nxt      = idx_r;
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    rise_hit_nxt = rise_hit_r;
    fall_hit_nxt = fall_hit_r;
    for (int d = 0; d < SEARCH_SPAN; d++) begin
      rise_idx_nxt[d] = rise_idx_r[d];
      fall_idx_nxt[d] = fall_idx_r[d];
    end
    if (start) begin
      idx_nxt      = '0;
      busy_nxt     = 1'b1;
      rise_hit_nxt = '0;
      fall_hit_nxt = '0;
    end else if (busy_r) begin
      for (int d = 0; d < SEARCH_SPAN; d++) begin
        if (in_rise && !rise_hit_r[d] &&
            entry == ({2'b00, hip_clamped} - 8'(d))) begin
          rise_hit_nxt[d] = 1'b1;
          rise_idx_nxt[d] = PHASE_W'(idx_r);
        end
        if (in_fall && !fall_hit_r[d] &&
            entry == ({2'b00, hip_clamped} + 8'(d))) begin
          fall_hit_nxt[d] = 1'b1;
          fall_idx_nxt[d] = PHASE_W'(idx_r);
        end
      end
      if (idx_r == IdxW'(ScanEnd - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      rise_hit_r <= '0;
      fall_hit_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      done_r     <= done_nxt;
      rise_hit_r <= rise_hit_nxt;
      fall_hit_r <= fall_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    for (int d = 0; d < SEARCH_SPAN; d++) begin
      rise_idx_r[d] <= rise_idx_nxt[d];
      fall_idx_r[d] <= fall_idx_nxt[d];
    end
  end

  // first offset with a hit past entry 0 wins; a hit at entry 0 drops that offset
  always_comb begin
    stat.done = done_r;
    stat.rise = '0;
    stat.fall = '0;
    for (int d = SEARCH_SPAN - 1; d >= 0; d--) begin
      if (rise_hit_r[d] && (rise_idx_r[d] != '0)) stat.rise = rise_idx_r[d];
      if (fall_hit_r[d] && (fall_idx_r[d] != '0)) stat.fall = fall_idx_r[d];
    end
  end

endmodule

// ===== rtl/gpjd_drive.sv =====
// ---------------------------------------------------------------------------
// gpjd_drive
// Motor code: quantizes measured and target knee/ankle angles and compares.
// Two register stages.
// ---------------------------------------------------------------------------
module gpjd_drive (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gpjd_pkg::PHASE_W-1:0] phase,
  input  logic [gpjd_pkg::ANG_W-1:0]   knee,
  input  logic [gpjd_pkg::ANG_W-1:0]   ankle,
  input  logic [7:0]                  ankle_offset,
  output logic                        done,
  output logic [gpjd_pkg::CODE_W-1:0]  code
);
  import gpjd_pkg::*;

  logic              v1_r, done_r;
  logic [4:0]        knee_q_r, knee_q_nxt;
  logic [4:0]        ankle_q_r, ankle_q_nxt;
  logic [2:0]        kt_q_r, kt_q_nxt;
  logic [8:0]        diff_r, diff_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [13:0]       knee_prod;
  logic [15:0]       ankle_prod;
  logic [7:0]        abs_diff;
  logic [15:0]       tgt_prod;
  logic [5:0]        at_q;
  logic [5:0]        at_tgt;

  always_comb begin
    knee_prod   = 14'(knee) * 14'(KNEE_RECIP);
    ankle_prod  = 16'(ankle) * 16'(ANKLE_RECIP);
    knee_q_nxt  = knee_prod[KNEE_SHIFT +: 5];
    ankle_q_nxt = ankle_prod[ANKLE_SHIFT +: 5];
    kt_q_nxt    = KNEE_Q_ROM[phase];
    diff_nxt    = {1'b0, ankle_offset} - {3'b000, ANKLE_ROM[phase]};
  end

  always_comb begin
    abs_diff = diff_r[8] ? 8'(-diff_r) : diff_r[7:0];
    tgt_prod = 16'(abs_diff) * 16'(ANKLE_RECIP);
    at_q     = {1'b0, tgt_prod[ANKLE_SHIFT +: 5]};
    at_tgt   = diff_r[8] ? -at_q : at_q;
    code_nxt = CODE_NONE;
    if (knee_q_r < {2'b00, kt_q_r}) code_nxt = code_nxt | CODE_KNEE_RAISE;
    else if (knee_q_r > {2'b00, kt_q_r}) code_nxt = code_nxt | CODE_KNEE_LOWER;
    if ($signed({1'b0, ankle_q_r}) < $signed(at_tgt)) begin
      code_nxt = code_nxt | CODE_ANKLE_RAISE;
    end else if ($signed({1'b0, ankle_q_r}) > $signed(at_tgt)) begin
      code_nxt = code_nxt | CODE_ANKLE_LOWER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      knee_q_r  <= knee_q_nxt;
      ankle_q_r <= ankle_q_nxt;
      kt_q_r    <= kt_q_nxt;
      diff_r    <= diff_nxt;
    end
    if (v1_r) begin
      code_r <= code_nxt;
    end
  end

  assign done = done_r;
  assign code = code_r;

endmodule

// ===== rtl/gait_phase_joint_drive_top.sv =====
// ---------------------------------------------------------------------------
// gait_phase_joint_drive_top
// Gait phase estimator: hip ROM search, candidate selection and joint drive.
// ---------------------------------------------------------------------------
// Step beat: scan of min(TABLE_LENGTH, 100) hip entries, then hand-off, select (an
//   extra select state under the wrap advance rule), drive and output load.
// Init beat: seeds the phase and goes straight to output load. One beat at a time;
//   in_tready returns with out_tvalid; a new beat is taken while a finished result
//   waits, a stalled result holds the next load.
// Reset (rst_n low, synchronous): last phase 0, registers to defaults, no result.
module gait_phase_joint_drive_top #(
  parameter int TABLE_LENGTH = gpjd_pkg::TABLE_LENGTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,  // hip_angle, knee_angle, ankle_angle
  input  logic [0:0]                     in_tuser,  // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // phase_index, motor_code, zero pad
  input  logic                           cfg_wr_en,
  input  logic [gpjd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gpjd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gpjd_pkg::*;

  state_t             state_r, state_nxt;
  logic [PHASE_W-1:0] last_phase_r, last_phase_nxt;
  logic [6:0]         late_thr_r;
  logic [7:0]         low_hip_r;
  logic [4:0]         phase_adv_r;
  logic [7:0]         ankle_ofs_r;
  logic [ANG_W-1:0]   hip_r, knee_r, ankle_r;
  logic [PHASE_W-1:0] res_phase_r, res_phase_nxt;
  logic [CODE_W-1:0]  res_code_r, res_code_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r;
  logic               load_out;
  logic               accept;
  logic               scan_start, drive_start, drive_done;
  logic [CODE_W-1:0]  drive_code;
  scan_stat_t         stat;
  logic [CLAMP_W-1:0] hip_clamped;
  logic [PHASE_W-1:0] dist_rise, dist_fall;
  logic               wrap;
  logic [7:0]         fall_adv;
  logic [PHASE_W-1:0] fall_adv_mod, fall_mod;
  logic [ANG_W-1:0]   in_hip;

  assign in_hip      = in_tdata[7:0];
  assign accept      = in_tvalid && in_tready;
  assign in_tready   = (state_r == ST_IDLE);
  assign hip_clamped = (hip_r > 8'(HIP_CLAMP)) ? HIP_CLAMP : hip_r[CLAMP_W-1:0];

  gpjd_scan #(
    .TABLE_LENGTH(TABLE_LENGTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .hip_clamped(hip_clamped),
    .stat       (stat)
  );

  gpjd_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (drive_start),
    .phase       (res_phase_r),
    .knee        (knee_r),
    .ankle       (ankle_r),
    .ankle_offset(ankle_ofs_r),
    .done        (drive_done),
    .code        (drive_code)
  );

  always_comb begin
    dist_rise    = (last_phase_r > stat.rise) ? last_phase_r - stat.rise
                                              : stat.rise - last_phase_r;
    dist_fall    = (last_phase_r > stat.fall) ? last_phase_r - stat.fall
                                              : stat.fall - last_phase_r;
    wrap         = (last_phase_r >= late_thr_r) && (hip_r <= low_hip_r);
    fall_adv     = {1'b0, stat.fall} + {3'b000, phase_adv_r};
    fall_adv_mod = (fall_adv >= PHASE_MOD) ? 7'(fall_adv - PHASE_MOD) : fall_adv[6:0];
    fall_mod     = ({1'b0, stat.fall} >= PHASE_MOD) ? 7'({1'b0, stat.fall} - PHASE_MOD)
                                                    : stat.fall;
  end

  always_comb begin
    state_nxt      = state_r;
    last_phase_nxt = last_phase_r;
    res_phase_nxt  = res_phase_r;
    res_code_nxt   = res_code_r;
    scan_start     = 1'b0;
    drive_start    = 1'b0;
    load_out       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == ACT_INIT) begin
            last_phase_nxt = (in_hip >= SEED_SPLIT) ? SEED_HIGH : SEED_LOW;
            res_phase_nxt  = last_phase_nxt;
            res_code_nxt   = CODE_NONE;
            state_nxt      = ST_OUT;
          end else begin
            res_phase_nxt = '0;
            scan_start    = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.done) state_nxt = ST_SEL1;
      end
      ST_SEL1: begin
        if (wrap) begin
          if (dist_rise < dist_fall) begin
            res_phase_nxt  = fall_adv_mod;
            last_phase_nxt = fall_adv_mod;
          end
          state_nxt = ST_SEL2;
        end else begin
          if (dist_rise < dist_fall) begin
            res_phase_nxt  = stat.rise;
            last_phase_nxt = stat.rise;
          end else if (dist_rise > dist_fall) begin
            res_phase_nxt  = fall_mod;
            last_phase_nxt = fall_mod;
          end
          state_nxt = ST_CODE;
        end
      end
      ST_SEL2: begin
        if (dist_rise > dist_fall) begin
          res_phase_nxt  = fall_mod;
          last_phase_nxt = fall_mod;
        end
        state_nxt = ST_CODE;
      end
      ST_CODE: begin
        drive_start = 1'b1;
        state_nxt   = ST_DRIVE;
      end
      ST_DRIVE: begin
        if (drive_done) begin
          res_code_nxt = drive_code;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_phase_r <= '0;
      out_valid_r  <= 1'b0;
      late_thr_r   <= RST_LATE_THR;
      low_hip_r    <= RST_LOW_HIP;
      phase_adv_r  <= RST_PHASE_ADV;
      ankle_ofs_r  <= RST_ANKLE_OFS;
    end else begin
      state_r      <= state_nxt;
      last_phase_r <= last_phase_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          CFG_LATE_THR:  late_thr_r  <= cfg_wdata[6:0];
          CFG_LOW_HIP:   low_hip_r   <= cfg_wdata;
          CFG_PHASE_ADV: phase_adv_r <= cfg_wdata[4:0];
          CFG_ANKLE_OFS: ankle_ofs_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_phase_r <= res_phase_nxt;
    res_code_r  <= res_code_nxt;
    if (accept) begin
      hip_r   <= in_tdata[7:0];
      knee_r  <= in_tdata[15:8];
      ankle_r <= in_tdata[23:16];
    end
    if (load_out) begin
      out_data_r <= {5'b00000, res_code_r, res_phase_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/gpjd_chk.sv =====
// ---------------------------------------------------------------------------
// gpjd_chk
// Port-level checks for the gait phase joint drive, bound to the top level.
// ---------------------------------------------------------------------------
module gpjd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_wr_en,
  input logic [1:0]  cfg_addr,
  input logic [7:0]  cfg_wdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] < 7'd100 && out_tdata[15:11] == 5'd0 &&
                   !(out_tdata[10] && out_tdata[9]) && !(out_tdata[8] && out_tdata[7]))
    else $error("malformed result beat");

endmodule

bind gait_phase_joint_drive_top gpjd_chk u_gpjd_chk (.*);
